// ===== hdl/button_debounce_click_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce and click classifier
// Shared wrappers that keep every concurrent check in one reporting style.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define BDCC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bdcc: invariant violated");

// A consequence that must hold in the same cycle as its trigger.
`define BDCC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdcc: implication violated");

`endif

// ===== hdl/bdcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdcc_pkg
// Types, register codes and reset values shared by the click classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bdcc_pkg;

    localparam int AddrW = 5;
    localparam int DataW = 32;

    localparam logic [11:0] ThresholdReset    = 12'd20;
    localparam logic [15:0] ReadIntervalReset = 16'd10;
    localparam logic [15:0] DebounceReset     = 16'd50;
    localparam logic [15:0] ClickTimeoutReset = 16'd400;
    localparam logic [15:0] LongPressReset    = 16'd1000;
    localparam logic [2:0]  TallyMax          = 3'd4;

    typedef enum logic [2:0] {
        REG_ANALOG_MODE   = 3'd0,
        REG_ACTIVE_LEVEL  = 3'd1,
        REG_THRESHOLD     = 3'd2,
        REG_READ_INTERVAL = 3'd3,
        REG_DEBOUNCE      = 3'd4,
        REG_CLICK_TIMEOUT = 3'd5,
        REG_LONG_PRESS    = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PRESSED = 2'd1,
        MODE_WAITING = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_ANY    = 3'd1,
        EV_SINGLE = 3'd2,
        EV_DOUBLE = 3'd3,
        EV_TRIPLE = 3'd4,
        EV_QUAD   = 3'd5,
        EV_LONG   = 3'd6
    } event_t;

    typedef struct packed {
        logic        analog_mode;
        logic        active_level;
        logic [11:0] analog_threshold;
        logic [15:0] read_interval_ms;
        logic [15:0] debounce_ms;
        logic [15:0] click_timeout_ms;
        logic [15:0] long_press_ms;
    } cfg_t;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic        pin_level;
        logic [11:0] analog_sample;
    } item_t;

    typedef struct packed {
        event_t ev;
        logic   level;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/bdcc_regs.sv =====
// ----------------------------------------------------------------------------
// bdcc_regs
// APB register file holding the classifier settings.
// ----------------------------------------------------------------------------
`default_nettype none

module bdcc_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bdcc_pkg::AddrW-1:0]  paddr,
    input  wire logic [bdcc_pkg::DataW-1:0]  pwdata,
    output logic      [bdcc_pkg::DataW-1:0]  prdata,
    output logic                             pready,
    output bdcc_pkg::cfg_t                   cfg
);

    bdcc_pkg::cfg_t     cfg_reg;
    bdcc_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = bdcc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.analog_mode      <= 1'b0;
            cfg_reg.active_level     <= 1'b0;
            cfg_reg.analog_threshold <= bdcc_pkg::ThresholdReset;
            cfg_reg.read_interval_ms <= bdcc_pkg::ReadIntervalReset;
            cfg_reg.debounce_ms      <= bdcc_pkg::DebounceReset;
            cfg_reg.click_timeout_ms <= bdcc_pkg::ClickTimeoutReset;
            cfg_reg.long_press_ms    <= bdcc_pkg::LongPressReset;
        end
        else if (wr_en)
        begin
            case (idx)
                bdcc_pkg::REG_ANALOG_MODE:   cfg_reg.analog_mode      <= pwdata[0];
                bdcc_pkg::REG_ACTIVE_LEVEL:  cfg_reg.active_level     <= pwdata[0];
                bdcc_pkg::REG_THRESHOLD:     cfg_reg.analog_threshold <= pwdata[11:0];
                bdcc_pkg::REG_READ_INTERVAL: cfg_reg.read_interval_ms <= pwdata[15:0];
                bdcc_pkg::REG_DEBOUNCE:      cfg_reg.debounce_ms      <= pwdata[15:0];
                bdcc_pkg::REG_CLICK_TIMEOUT: cfg_reg.click_timeout_ms <= pwdata[15:0];
                bdcc_pkg::REG_LONG_PRESS:    cfg_reg.long_press_ms    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bdcc_pkg::REG_ANALOG_MODE:   prdata = {31'd0, cfg_reg.analog_mode};
            bdcc_pkg::REG_ACTIVE_LEVEL:  prdata = {31'd0, cfg_reg.active_level};
            bdcc_pkg::REG_THRESHOLD:     prdata = {20'd0, cfg_reg.analog_threshold};
            bdcc_pkg::REG_READ_INTERVAL: prdata = {16'd0, cfg_reg.read_interval_ms};
            bdcc_pkg::REG_DEBOUNCE:      prdata = {16'd0, cfg_reg.debounce_ms};
            bdcc_pkg::REG_CLICK_TIMEOUT: prdata = {16'd0, cfg_reg.click_timeout_ms};
            bdcc_pkg::REG_LONG_PRESS:    prdata = {16'd0, cfg_reg.long_press_ms};
            default:                     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/bdcc_core.sv =====
// ----------------------------------------------------------------------------
// bdcc_core
// Debounce and click classification state with its next-state update logic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_click_classifier_defines.svh"

module bdcc_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bdcc_pkg::cfg_t  cfg,
    input  wire logic            step_en,
    input  wire bdcc_pkg::item_t item,
    output bdcc_pkg::result_t    res
);

    logic                stable_reg, stable_next;
    logic                prev_reg, prev_next;
    logic [31:0]         last_reg, last_next;
    logic [31:0]         change_reg, change_next;
    logic [31:0]         press_reg, press_next;
    logic [31:0]         release_reg, release_next;
    bdcc_pkg::mode_t     mode_reg, mode_next;
    logic [2:0]          tally_reg, tally_next;
    bdcc_pkg::event_t    ev;
    logic                s;
    logic [31:0]         now;
    logic                click_ev;
    logic                long_ev;

    assign now = item.now_ms;
    assign s   = cfg.analog_mode ? (item.analog_sample < cfg.analog_threshold)
                                 : (item.pin_level == cfg.active_level);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg  <= 1'b0;
            prev_reg    <= 1'b0;
            last_reg    <= '0;
            change_reg  <= '0;
            press_reg   <= '0;
            release_reg <= '0;
            mode_reg    <= bdcc_pkg::MODE_IDLE;
            tally_reg   <= '0;
        end
        else
        begin
            stable_reg  <= stable_next;
            prev_reg    <= prev_next;
            last_reg    <= last_next;
            change_reg  <= change_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            mode_reg    <= mode_next;
            tally_reg   <= tally_next;
        end
    end

    // Each later check sees the times already updated earlier in the same beat,
    // so a stamp taken now yields a zero difference.
    always_comb
    begin
        stable_next  = stable_reg;
        prev_next    = prev_reg;
        last_next    = last_reg;
        change_next  = change_reg;
        press_next   = press_reg;
        release_next = release_reg;
        mode_next    = mode_reg;
        tally_next   = tally_reg;
        ev           = bdcc_pkg::EV_NONE;
        if (step_en)
        begin
            if (item.action)
            begin
                stable_next = s;
                prev_next   = s;
            end
            else if ((now - last_reg) >= {16'd0, cfg.read_interval_ms})
            begin
                last_next = now;
                if (s != prev_reg)
                begin
                    change_next = now;
                end
                if (((now - change_next) > {16'd0, cfg.debounce_ms}) && (s != stable_reg))
                begin
                    stable_next = s;
                    if (s)
                    begin
                        press_next = now;
                        mode_next  = bdcc_pkg::MODE_PRESSED;
                        ev         = bdcc_pkg::EV_ANY;
                    end
                    else if (mode_reg == bdcc_pkg::MODE_PRESSED)
                    begin
                        if ((now - press_reg) < {16'd0, cfg.long_press_ms})
                        begin
                            if (tally_reg < bdcc_pkg::TallyMax)
                            begin
                                tally_next = tally_reg + 3'd1;
                            end
                            release_next = now;
                            mode_next    = bdcc_pkg::MODE_WAITING;
                        end
                        else
                        begin
                            mode_next  = bdcc_pkg::MODE_IDLE;
                            tally_next = '0;
                        end
                    end
                end
                prev_next = s;

                if ((mode_next == bdcc_pkg::MODE_WAITING) &&
                    ((now - release_next) > {16'd0, cfg.click_timeout_ms}))
                begin
                    if (tally_next >= bdcc_pkg::TallyMax)
                    begin
                        ev = bdcc_pkg::EV_QUAD;
                    end
                    else if (tally_next == 3'd3)
                    begin
                        ev = bdcc_pkg::EV_TRIPLE;
                    end
                    else if (tally_next == 3'd2)
                    begin
                        ev = bdcc_pkg::EV_DOUBLE;
                    end
                    else if (tally_next == 3'd1)
                    begin
                        ev = bdcc_pkg::EV_SINGLE;
                    end
                    tally_next = '0;
                    mode_next  = bdcc_pkg::MODE_IDLE;
                end
                if ((mode_next == bdcc_pkg::MODE_PRESSED) &&
                    ((now - press_next) > {16'd0, cfg.long_press_ms}))
                begin
                    ev         = bdcc_pkg::EV_LONG;
                    mode_next  = bdcc_pkg::MODE_IDLE;
                    tally_next = '0;
                end
            end
        end
    end

    assign res.ev    = ev;
    assign res.level = stable_next;

    // Click reports and long presses, used by the checks below.
    assign click_ev = ev inside {bdcc_pkg::EV_SINGLE, bdcc_pkg::EV_DOUBLE,
                                 bdcc_pkg::EV_TRIPLE, bdcc_pkg::EV_QUAD};
    assign long_ev  = (ev == bdcc_pkg::EV_LONG);

    `BDCC_ASSERT_ALWAYS(a_tally_sat, clk, rst_n, tally_reg <= bdcc_pkg::TallyMax)
    `BDCC_ASSERT_IMPLY(a_idle_clear, clk, rst_n, mode_reg == bdcc_pkg::MODE_IDLE, tally_reg == '0)
    `BDCC_ASSERT_IMPLY(a_long_held, clk, rst_n, long_ev, mode_reg == bdcc_pkg::MODE_PRESSED)
    `BDCC_ASSERT_IMPLY(a_click_wait, clk, rst_n, click_ev, mode_reg == bdcc_pkg::MODE_WAITING)

endmodule

`default_nettype wire

// ===== hdl/button_debounce_click_classifier.sv =====
// Path: a sample beat is held in the input register once accepted, and its
// result is captured in the result register when the held beat advances.
// Throughput: one beat per cycle while result_stall is low.
// Reset: rst_n clears all classifier state, the pipeline valids and the
// settings to their defaults at once; no clearing pass follows.
// ----------------------------------------------------------------------------
// button_debounce_click_classifier
// Debounces a timestamped button sample stream and reports press, multi-click
// and long-press events, one result beat per sample beat.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_click_classifier (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Sample channel
    input  wire logic                        sample_valid,
    output logic                             sample_stall,
    input  wire logic                        action,
    input  wire logic [31:0]                 now_ms,
    input  wire logic                        pin_level,
    input  wire logic [11:0]                 analog_sample,
    // Result channel
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic [2:0]                       event_code,
    output logic                             debounced_level,
    // Configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bdcc_pkg::AddrW-1:0]  paddr,
    input  wire logic [bdcc_pkg::DataW-1:0]  pwdata,
    output logic      [bdcc_pkg::DataW-1:0]  prdata,
    output logic                             pready
);

    bdcc_pkg::cfg_t    cfg;
    bdcc_pkg::item_t   item_reg;
    bdcc_pkg::result_t step_res;
    bdcc_pkg::result_t result_reg;
    logic              in_full_reg, in_full_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              advance;

    bdcc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held sample moves into the classifier whenever the result register
    // is empty or its beat is being taken this cycle. The input register can
    // therefore take a new beat while a finished result still waits.
    assign advance      = in_full_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = in_full_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    assign in_full_next   = accept || (in_full_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load only on their handshakes and need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action        <= action;
            item_reg.now_ms        <= now_ms;
            item_reg.pin_level     <= pin_level;
            item_reg.analog_sample <= analog_sample;
        end
        if (advance)
        begin
            result_reg <= step_res;
        end
    end

    // The classifier state is updated in the same cycle that the held sample
    // advances, so the following sample sees its effect immediately.
    bdcc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (advance),
        .item    (item_reg),
        .res     (step_res)
    );

    assign result_valid    = out_valid_reg;
    assign event_code      = result_reg.ev;
    assign debounced_level = result_reg.level;

endmodule

`default_nettype wire
